// ===== src/jhe_pkg.sv =====
package jhe_pkg;

    // Block and table geometry that the coding scheme fixes.
    localparam int BLOCK_COEFFS   = 64;
    localparam int AC_TABLE_DEPTH = 256;
    localparam int AC_IDX_W       = $clog2(AC_TABLE_DEPTH);

    // Result buffer: at most this many stream bytes are kept for one item.
    localparam int MAX_BYTES = 20;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);

    // Bit packer accumulator: up to seven pending bits plus one 16-bit code.
    localparam int ACC_W = 23;
    localparam int LEN_W = 5;

    localparam logic [AC_IDX_W-1:0] ZRL_SYMBOL   = 8'hF0;
    localparam logic [AC_IDX_W-1:0] EOB_SYMBOL   = 8'h00;
    localparam logic [7:0]          BYTE_FF      = 8'hFF;
    localparam logic [7:0]          BYTE_STUFF   = 8'h00;
    localparam logic [15:0]         FLUSH_CODE   = 16'h007F;
    localparam logic [LEN_W-1:0]    FLUSH_LEN    = 5'd7;
    localparam logic [LEN_W-1:0]    MAX_CODE_LEN = 5'd16;
    localparam logic [10:0]         COEF_NEG_MIN = 11'h400;
    localparam logic [10:0]         COEF_SAT     = 11'h401;

    typedef enum logic [1:0] {
        OP_COEF    = 2'd0,
        OP_LOAD_DC = 2'd1,
        OP_LOAD_AC = 2'd2,
        OP_FLUSH   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COEF,
        S_DC_ENT,
        S_ZRL,
        S_AC_ENT,
        S_RAW,
        S_END,
        S_EOB,
        S_DRAIN,
        S_FLUSH,
        S_FCLR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [15:0]      code;
    } t_entry;

    typedef struct packed {
        logic             put;
        logic             clear;
        logic [15:0]      code;
        logic [LEN_W-1:0] size;
    } t_pack_cmd;

    typedef struct packed {
        logic       idle;
        logic       pend_nz;
        logic       wr_en;
        logic [7:0] wr_byte;
    } t_pack_stat;

    // Size category: the position of the highest set bit, plus one.
    function automatic logic [3:0] category(input logic [10:0] mag);
        logic [3:0] nb;
        nb = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (mag[i]) begin
                nb = 4'(i + 1);
            end
        end
        return nb;
    endfunction

endpackage

// ===== src/jhe_in_if.sv =====
interface jhe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [10:0] coefficient;
    logic [7:0]  entry_index;
    logic [15:0] entry_code;
    logic [4:0]  entry_length;

    modport source (
        output valid, opcode, coefficient, entry_index, entry_code, entry_length,
        input  ready
    );
    modport sink (
        input  valid, opcode, coefficient, entry_index, entry_code, entry_length,
        output ready
    );
endinterface

// ===== src/jhe_out_if.sv =====
interface jhe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_item;
    logic       status;

    modport source (
        output valid, out_byte, byte_valid, last_of_item, status,
        input  ready
    );
    modport sink (
        input  valid, out_byte, byte_valid, last_of_item, status,
        output ready
    );
endinterface

// ===== src/jhe_packer.sv =====
module jhe_packer (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  jhe_pkg::t_pack_cmd     i_cmd,
    output jhe_pkg::t_pack_stat    o_stat
);
    import jhe_pkg::*;

    logic [ACC_W-1:0] r_acc;
    logic [LEN_W-1:0] r_n;
    logic             r_stuff;

    logic [ACC_W-1:0] mask_n;
    logic [ACC_W-1:0] mask_s;
    logic [ACC_W-1:0] load_acc;
    logic [7:0]       drain_byte;
    logic             has_byte;

    // Only the low r_n bits of the accumulator are live.
    always_comb begin
        mask_n     = (ACC_W'(1) << r_n) - ACC_W'(1);
        mask_s     = (ACC_W'(1) << i_cmd.size) - ACC_W'(1);
        load_acc   = ((r_acc & mask_n) << i_cmd.size) | (ACC_W'(i_cmd.code) & mask_s);
        drain_byte = 8'(r_acc >> (r_n - LEN_W'(8)));
        has_byte   = (r_n >= LEN_W'(8));
    end

    always_comb begin
        o_stat.idle    = !r_stuff && !has_byte;
        o_stat.pend_nz = (r_n != '0);
        o_stat.wr_en   = r_stuff || has_byte;
        o_stat.wr_byte = r_stuff ? BYTE_STUFF : drain_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n     <= '0;
            r_stuff <= 1'b0;
        end else if (r_stuff) begin
            r_stuff <= 1'b0;
        end else if (has_byte) begin
            r_n     <= r_n - LEN_W'(8);
            r_stuff <= (drain_byte == BYTE_FF);
        end else if (i_cmd.put) begin
            r_n <= r_n + i_cmd.size;
        end else if (i_cmd.clear) begin
            r_n <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!has_byte && !r_stuff && i_cmd.put) begin
            r_acc <= load_acc;
        end
    end

endmodule

// ===== src/jpeg_huffman_block_encoder_unit.sv =====
// Channel   Modport           Beat contents
// i_in      jhe_in_if.sink    opcode, coefficient, entry_index, entry_code, entry_length
// o_out     jhe_out_if.source out_byte, byte_valid, last_of_item, status
//
// One item is worked on at a time. A table load gives a single result beat.
// A coefficient passes through S_COEF and then its code steps, whether the code is put
// or dropped, each waiting until the packer has drained its bytes and stuffed zeros;
// then S_END, S_EOB when a block ends in a zero run, S_DRAIN and its result beats.
// A flush passes through S_FLUSH and S_FCLR, where the packer drains its padded bytes
// and stuffed zeros, and then gives its result beats. The bit packer moves one byte a
// cycle, and the table reads are registered.
// Reset is synchronous and active low; it clears the sequencer, the packer, the
// predictor and the block position. The code tables are undefined until loaded.
// A stall on o_out holds the block in its result phase; i_in stays not ready until the
// last beat of the item is taken.
module jpeg_huffman_block_encoder_unit #(
    parameter int DC_TABLE_DEPTH = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jhe_in_if.sink           i_in,
    jhe_out_if.source        o_out
);
    import jhe_pkg::*;

    localparam int DC_IDX_W = $clog2(DC_TABLE_DEPTH);

    // Sequencer and block state.
    t_state              r_state, n_state;
    logic signed [10:0]  r_coef,  n_coef;
    logic signed [10:0]  r_pred,  n_pred;
    logic [5:0]          r_pos,   n_pos;
    logic [5:0]          r_run,   n_run;
    logic [3:0]          r_nb,    n_nb;
    logic [10:0]         r_raw,   n_raw;
    logic                r_fault, n_fault;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_oidx,  n_oidx;

    // Result buffer, filled by the packer and emptied in the result phase.
    logic [7:0]          r_buf [MAX_BYTES];

    // Code tables: synchronous, registered reads.
    t_entry              dc_mem [DC_TABLE_DEPTH];
    t_entry              ac_mem [AC_TABLE_DEPTH];
    t_entry              r_dc_rd;
    t_entry              r_ac_rd;
    logic                dc_rd_en;
    logic [DC_IDX_W-1:0] dc_rd_addr;
    logic                ac_rd_en;
    logic [AC_IDX_W-1:0] ac_rd_addr;
    logic                dc_we;
    logic                ac_we;
    t_entry              load_ent;

    t_pack_cmd           pk_cmd;
    t_pack_stat          pk_stat;

    logic                in_acc;
    logic                out_acc;
    logic                out_last;
    t_opcode             in_op;

    // Coefficient arithmetic.
    logic signed [11:0]  dc_diff;
    logic [11:0]         dc_mag;
    logic [3:0]          dc_nb;
    logic [10:0]         dc_raw;
    logic [10:0]         ac_mag;
    logic [3:0]          ac_nb;
    logic [10:0]         ac_raw;
    logic [5:0]          run_m16;
    logic                last_pos;

    logic                do_ent;
    t_entry              sel_ent;

    assign in_op    = t_opcode'(i_in.opcode);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_acc  = o_out.valid && o_out.ready;
    assign out_last = (r_cnt == '0) || (r_oidx == r_cnt - CNT_W'(1));
    assign run_m16  = r_run - 6'd16;
    assign last_pos = (r_pos == 6'(BLOCK_COEFFS - 1));

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = (r_state == S_OUT);
    assign o_out.byte_valid   = (r_cnt != '0);
    assign o_out.out_byte     = (r_cnt != '0) ? r_buf[r_oidx] : 8'h00;
    assign o_out.last_of_item = out_last;
    assign o_out.status       = r_fault;

    // The DC difference is one bit wider than the coefficient; its magnitude still fits
    // in eleven bits, and so do the offset bits that follow the category code.
    always_comb begin
        dc_diff = 12'(r_coef) - 12'(r_pred);
        dc_mag  = dc_diff[11] ? 12'(-dc_diff) : 12'(dc_diff);
        dc_nb   = category(dc_mag[10:0]);
        dc_raw  = dc_diff[11] ? 11'(dc_diff - 12'sd1) : dc_diff[10:0];
        ac_mag  = r_coef[10] ? 11'(-r_coef) : 11'(r_coef);
        ac_nb   = category(ac_mag);
        ac_raw  = r_coef[10] ? 11'(r_coef - 11'sd1) : r_coef;
    end

    // A loaded length over sixteen is held at sixteen.
    always_comb begin
        load_ent.len  = (i_in.entry_length > MAX_CODE_LEN) ? MAX_CODE_LEN : i_in.entry_length;
        load_ent.code = i_in.entry_code;
        dc_we = in_acc && (in_op == OP_LOAD_DC) && (i_in.entry_index < 8'(DC_TABLE_DEPTH));
        ac_we = in_acc && (in_op == OP_LOAD_AC);
    end

    always_ff @(posedge i_clk) begin
        if (dc_we) begin
            dc_mem[i_in.entry_index[DC_IDX_W-1:0]] <= load_ent;
        end
        if (dc_rd_en) begin
            r_dc_rd <= dc_mem[dc_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ac_we) begin
            ac_mem[i_in.entry_index[AC_IDX_W-1:0]] <= load_ent;
        end
        if (ac_rd_en) begin
            r_ac_rd <= ac_mem[ac_rd_addr];
        end
    end

    jhe_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pk_cmd),
        .o_stat  (pk_stat)
    );

    // Next state. Every step that puts a code waits until the packer has drained.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (in_op)
                        OP_COEF:    n_state = S_COEF;
                        OP_LOAD_DC: n_state = S_OUT;
                        OP_LOAD_AC: n_state = S_OUT;
                        OP_FLUSH:   n_state = S_FLUSH;
                    endcase
                end
            end
            S_COEF: begin
                priority if (r_pos == '0)      n_state = S_DC_ENT;
                else if (r_coef == '0)         n_state = S_END;
                else if (r_run > 6'd15)        n_state = S_ZRL;
                else                           n_state = S_AC_ENT;
            end
            S_DC_ENT: begin
                if (pk_stat.idle) begin
                    n_state = (r_nb != '0) ? S_RAW : S_END;
                end
            end
            S_ZRL: begin
                if (pk_stat.idle) begin
                    n_state = (run_m16 > 6'd15) ? S_ZRL : S_AC_ENT;
                end
            end
            S_AC_ENT: begin
                if (pk_stat.idle) begin
                    n_state = S_RAW;
                end
            end
            S_RAW: begin
                if (pk_stat.idle) begin
                    n_state = S_END;
                end
            end
            S_END: begin
                n_state = (last_pos && r_run != '0) ? S_EOB : S_DRAIN;
            end
            S_EOB: begin
                if (pk_stat.idle) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (pk_stat.idle) begin
                    n_state = S_OUT;
                end
            end
            S_FLUSH: begin
                n_state = S_FCLR;
            end
            S_FCLR: begin
                if (pk_stat.idle) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_acc && out_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, table reads and packer commands.
    always_comb begin
        n_coef     = r_coef;
        n_pred     = r_pred;
        n_pos      = r_pos;
        n_run      = r_run;
        n_nb       = r_nb;
        n_raw      = r_raw;
        n_fault    = r_fault;
        n_oidx     = r_oidx;
        dc_rd_en   = 1'b0;
        dc_rd_addr = DC_IDX_W'(dc_nb);
        ac_rd_en   = 1'b0;
        ac_rd_addr = EOB_SYMBOL;
        pk_cmd     = '0;
        do_ent     = 1'b0;
        sel_ent    = r_ac_rd;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_coef  = (i_in.coefficient == COEF_NEG_MIN) ? COEF_SAT
                                                                 : i_in.coefficient;
                    n_fault = 1'b0;
                    n_oidx  = '0;
                end
            end
            S_COEF: begin
                priority if (r_pos == '0) begin
                    dc_rd_en = 1'b1;
                    n_pred   = r_coef;
                    n_nb     = dc_nb;
                    n_raw    = dc_raw;
                end else if (r_coef == '0) begin
                    n_run = r_run + 6'd1;
                end else begin
                    n_nb       = ac_nb;
                    n_raw      = ac_raw;
                    ac_rd_en   = 1'b1;
                    ac_rd_addr = (r_run > 6'd15) ? ZRL_SYMBOL : {r_run[3:0], ac_nb};
                end
            end
            S_DC_ENT: begin
                do_ent  = pk_stat.idle;
                sel_ent = r_dc_rd;
            end
            S_ZRL: begin
                // Each pass codes sixteen zeros and fetches the next symbol ahead.
                if (pk_stat.idle) begin
                    do_ent     = 1'b1;
                    n_run      = run_m16;
                    ac_rd_en   = 1'b1;
                    ac_rd_addr = (run_m16 > 6'd15) ? ZRL_SYMBOL : {run_m16[3:0], r_nb};
                end
            end
            S_AC_ENT: begin
                if (pk_stat.idle) begin
                    do_ent = 1'b1;
                    n_run  = '0;
                end
            end
            S_RAW: begin
                if (pk_stat.idle && !r_fault) begin
                    pk_cmd.put  = 1'b1;
                    pk_cmd.code = 16'(r_raw);
                    pk_cmd.size = LEN_W'(r_nb);
                end
            end
            S_END: begin
                if (last_pos) begin
                    ac_rd_en   = (r_run != '0);
                    ac_rd_addr = EOB_SYMBOL;
                    n_pos      = '0;
                    n_run      = '0;
                end else begin
                    n_pos = r_pos + 6'd1;
                end
            end
            S_EOB: begin
                do_ent = pk_stat.idle;
            end
            S_DRAIN: begin
            end
            S_FLUSH: begin
                // The packer is always drained when an item starts.
                if (pk_stat.pend_nz) begin
                    pk_cmd.put  = 1'b1;
                    pk_cmd.code = FLUSH_CODE;
                    pk_cmd.size = FLUSH_LEN;
                end
                n_pred = '0;
                n_pos  = '0;
                n_run  = '0;
            end
            S_FCLR: begin
                pk_cmd.clear = pk_stat.idle;
            end
            S_OUT: begin
                if (out_acc) begin
                    n_oidx = r_oidx + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase

        // A table code of length zero stops all further coding of this item.
        if (do_ent && !r_fault) begin
            if (sel_ent.len == '0) begin
                n_fault = 1'b1;
            end else begin
                pk_cmd.put  = 1'b1;
                pk_cmd.code = sel_ent.code;
                pk_cmd.size = sel_ent.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pred  <= '0;
            r_pos   <= '0;
            r_run   <= '0;
            r_fault <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_pred  <= n_pred;
            r_pos   <= n_pos;
            r_run   <= n_run;
            r_fault <= n_fault;
            r_oidx  <= n_oidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
        r_nb   <= n_nb;
        r_raw  <= n_raw;
    end

    // Bytes beyond the buffer depth are dropped; the packer keeps its bit position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc) begin
            r_cnt <= '0;
        end else if (pk_stat.wr_en && r_cnt < CNT_W'(MAX_BYTES)) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pk_stat.wr_en && r_cnt < CNT_W'(MAX_BYTES)) begin
            r_buf[r_cnt] <= pk_stat.wr_byte;
        end
    end

endmodule

// ===== src/jhe_checker.sv =====
module jhe_port_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_byte_valid,
    input logic       i_last,
    input logic       i_status
);

    // Results of one item are delivered before the next item is taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while results are still pending");

    // A beat without a stream byte is the only beat of its item.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_byte_valid) |-> i_last)
        else $error("empty beat not marked last");

    // Status belongs to the whole item and cannot change between its beats.
    a_status_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last) |=> (i_out_valid && i_status == $past(i_status)))
        else $error("status changed within an item");

    // A stalled beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte) && $stable(i_last)))
        else $error("stalled beat changed");

endmodule

bind jpeg_huffman_block_encoder_unit jhe_port_props u_jhe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_byte_valid (o_out.byte_valid),
    .i_last       (o_out.last_of_item),
    .i_status     (o_out.status)
);

// ===== sim/jhe_checker.sv =====
`timescale 1ns / 100ps

module jhe_checker #(
    parameter int DC_DEPTH = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    jhe_in_if    i_in,
    jhe_out_if   i_out,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_beat_count
);
    import jhe_pkg::*;

    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       last;
        logic       status;
    } t_stream_beat;

    // Our own copy of the code tables and of the packer and block state.
    t_entry       dc_codes [DC_DEPTH];
    t_entry       ac_codes [AC_TABLE_DEPTH];
    logic [6:0]   pend_bits;
    int           pend_cnt;
    int           dc_pred;
    int           coef_pos;
    int           zrun;
    logic [7:0]   item_bytes [$];
    bit           item_fault;
    t_stream_beat expected_beats [$];
    int           mismatches;
    int           beats;

    task automatic emit_byte(input logic [7:0] b);
        if (item_bytes.size() < MAX_BYTES) begin
            item_bytes.push_back(b);
        end
        if (b == BYTE_FF && item_bytes.size() < MAX_BYTES) begin
            item_bytes.push_back(BYTE_STUFF);
        end
    endtask

    // Appends a code MSB first; a zero length drops it and the rest of the item.
    task automatic pack_bits(input logic [15:0] code, input int size);
        logic [31:0] acc;
        int          n;
        if (item_fault) begin
            return;
        end
        if (size == 0) begin
            item_fault = 1'b1;
            return;
        end
        if (size > 16) begin
            size = 16;
        end
        acc = ({25'd0, pend_bits} << size) | ({16'd0, code} & ((32'd1 << size) - 32'd1));
        n   = pend_cnt + size;
        while (n >= 8) begin
            emit_byte(8'(acc >> (n - 8)));
            n -= 8;
        end
        pend_bits = 7'(acc & ((32'd1 << n) - 32'd1));
        pend_cnt  = n;
    endtask

    task automatic pack_entry(input t_entry e);
        pack_bits(e.code, int'(e.len));
    endtask

    function automatic int size_class(input int mag);
        int n;
        n = 0;
        while (mag != 0) begin
            n++;
            mag >>= 1;
        end
        return n;
    endfunction

    task automatic code_coef(input int c);
        int diff;
        int mag;
        int nb;
        if (coef_pos == 0) begin
            diff    = c - dc_pred;
            mag     = (diff < 0) ? -diff : diff;
            nb      = size_class(mag);
            dc_pred = c;
            pack_entry((nb < DC_DEPTH) ? dc_codes[nb] : '0);
            if (nb != 0) begin
                pack_bits(16'((diff < 0) ? diff - 1 : diff), nb);
            end
        end else if (c == 0) begin
            zrun = (zrun + 1) & 63;
        end else begin
            mag = (c < 0) ? -c : c;
            nb  = size_class(mag);
            while (zrun > 15) begin
                pack_entry(ac_codes[ZRL_SYMBOL]);
                zrun -= 16;
            end
            pack_entry(ac_codes[8'((zrun << 4) + nb)]);
            pack_bits(16'((c < 0) ? c - 1 : c), nb);
            zrun = 0;
        end
        if (coef_pos >= BLOCK_COEFFS - 1) begin
            if (zrun > 0) begin
                pack_entry(ac_codes[EOB_SYMBOL]);
            end
            coef_pos = 0;
            zrun     = 0;
        end else begin
            coef_pos++;
        end
    endtask

    task automatic predict_item(input t_opcode op, input logic [10:0] raw,
                                input logic [7:0] idx, input logic [15:0] code,
                                input logic [4:0] len);
        t_entry       ent;
        int           c;
        t_stream_beat b;
        item_bytes.delete();
        item_fault = 1'b0;
        ent.len    = (len > MAX_CODE_LEN) ? MAX_CODE_LEN : len;
        ent.code   = code;
        case (op)
            OP_COEF: begin
                c = int'($signed(raw));
                if (c < -1023) begin
                    c = -1023;
                end
                code_coef(c);
            end
            OP_LOAD_DC: begin
                if (idx < DC_DEPTH) begin
                    dc_codes[idx] = ent;
                end
            end
            OP_LOAD_AC: begin
                ac_codes[idx] = ent;
            end
            OP_FLUSH: begin
                if (pend_cnt > 0) begin
                    pack_bits(FLUSH_CODE, int'(FLUSH_LEN));
                end
                pend_bits = '0;
                pend_cnt  = 0;
                dc_pred   = 0;
                coef_pos  = 0;
                zrun      = 0;
            end
        endcase
        if (item_bytes.size() == 0) begin
            b.data       = '0;
            b.data_valid = 1'b0;
            b.last       = 1'b1;
            b.status     = item_fault;
            expected_beats.push_back(b);
        end else begin
            foreach (item_bytes[k]) begin
                b.data       = item_bytes[k];
                b.data_valid = 1'b1;
                b.last       = (k == item_bytes.size() - 1);
                b.status     = item_fault;
                expected_beats.push_back(b);
            end
        end
    endtask

    task automatic check_beat();
        t_stream_beat got;
        t_stream_beat want;
        got.data       = i_out.out_byte;
        got.data_valid = i_out.byte_valid;
        got.last       = i_out.last_of_item;
        got.status     = i_out.status;
        beats++;
        if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
                $display("%0t: unexpected beat, got byte %02h valid %0b last %0b status %0b",
                         $time, got.data, got.data_valid, got.last, got.status);
            end
        end else begin
            want = expected_beats.pop_front();
            if (got.data !== want.data || got.data_valid !== want.data_valid ||
                got.last !== want.last || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_CAP) begin
                    $display("%0t: beat mismatch, expected byte %02h valid %0b last %0b status %0b",
                             $time, want.data, want.data_valid, want.last, want.status);
                    $display("%0t:                got      byte %02h valid %0b last %0b status %0b",
                             $time, got.data, got.data_valid, got.last, got.status);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pend_bits  = '0;
            pend_cnt   = 0;
            dc_pred    = 0;
            coef_pos   = 0;
            zrun       = 0;
            mismatches = 0;
            beats      = 0;
            expected_beats.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                predict_item(t_opcode'(i_in.opcode), i_in.coefficient, i_in.entry_index,
                             i_in.entry_code, i_in.entry_length);
            end
            if (i_out.valid && i_out.ready) begin
                check_beat();
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_beats.size();
        o_beat_count  <= beats;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import jhe_pkg::*;

    // The unit is built with the smallest DC table that still covers every
    // size category of a difference between two saturated coefficients.
    localparam int DC_DEPTH     = 12;
    localparam int RANDOM_ITEMS = 220;
    // One long hold-off on the result side, so that the unit fills up and
    // stalls its input while the sender keeps offering beats.
    localparam int LONG_STALL   = 400;
    // The only long silence on either channel is the hold-off above;
    // the watchdog limit is set above it.
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 60;

    logic i_clk;
    logic i_rst_n;

    jhe_in_if  in_ch ();
    jhe_out_if out_ch ();

    int fail_count;
    int outstanding;
    int beat_count;

    // Shared between the sender and the receiver: a stretch without idling,
    // and a request for the long hold-off that the receiver counts itself.
    bit steady;
    int stall_asked;
    int stall_served;

    int n_sent;
    int n_coefs;
    int n_loads;
    int n_flushes;
    int n_blocks;

    jpeg_huffman_block_encoder_unit #(
        .DC_TABLE_DEPTH(DC_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    jhe_checker #(
        .DC_DEPTH(DC_DEPTH)
    ) u_stream_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .o_beat_count (beat_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one beat from a falling edge and holds it until it is taken.
    // It returns at the falling edge after the handshake, so the next call
    // can drive straight on without dropping valid in between.
    task automatic send_item(input t_opcode op, input logic [10:0] coef,
                             input logic [7:0] idx, input logic [15:0] code,
                             input logic [4:0] len);
        if (!steady && $urandom_range(99) < 15) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= op;
        in_ch.coefficient  <= coef;
        in_ch.entry_index  <= idx;
        in_ch.entry_code   <= code;
        in_ch.entry_length <= len;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        case (op)
            OP_COEF:    n_coefs++;
            OP_FLUSH:   n_flushes++;
            default:    n_loads++;
        endcase
        // A DC load beyond the table is simply dropped by the unit.
        if (!(op == OP_LOAD_DC && idx >= DC_DEPTH)) begin
            n_sent++;
        end
    endtask

    task automatic send_coef(input logic [10:0] c);
        send_item(OP_COEF, c, 8'($urandom), 16'($urandom), 5'($urandom));
    endtask

    task automatic send_flush();
        send_item(OP_FLUSH, 11'($urandom), 8'($urandom), 16'($urandom), 5'($urandom));
    endtask

    // Drops valid and waits until every expected beat has been checked.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    // Nonzero AC value: a random size category, then a value within it,
    // now and then the raw pattern of -1024 that the unit saturates.
    function automatic logic [10:0] ac_value();
        int cat;
        int mag;
        if ($urandom_range(99) < 3) begin
            return COEF_NEG_MIN;
        end
        cat = $urandom_range(10, 1);
        mag = $urandom_range((1 << cat) - 1, 1 << (cat - 1));
        return $urandom_range(1) ? 11'(-mag) : 11'(mag);
    endfunction

    // DC values lean on the extremes so that large differences turn up.
    function automatic logic [10:0] dc_value();
        case ($urandom_range(5))
            0:       return 11'd1023;
            1:       return 11'(-1023);
            2:       return COEF_NEG_MIN;
            3:       return 11'd0;
            default: return 11'($urandom);
        endcase
    endfunction

    // Code lengths: mostly legal, some too long (saturated on load) and a
    // few of zero, which mark the entry as invalid.
    function automatic logic [4:0] entry_len();
        int r;
        r = $urandom_range(99);
        if (r < 80) begin
            return 5'($urandom_range(16, 1));
        end else if (r < 90) begin
            return 5'($urandom_range(31, 17));
        end
        return 5'd0;
    endfunction

    // A well-formed block of 64 coefficients with random content. Density
    // and the position of the last nonzero value vary, so that long zero
    // runs (ZRL), trailing zeros (EOB) and full blocks all occur. Now and
    // then a block is cut short and closed by a flush.
    task automatic coef_block(input bit forced, input logic [10:0] dc);
        int len;
        int last_nz;
        int density;
        len     = (!forced && $urandom_range(99) < 10) ? $urandom_range(63, 1) : BLOCK_COEFFS;
        last_nz = forced ? BLOCK_COEFFS - 1 : $urandom_range(BLOCK_COEFFS - 1);
        case ($urandom_range(2))
            0:       density = $urandom_range(15, 3);
            1:       density = $urandom_range(50, 16);
            default: density = $urandom_range(100, 51);
        endcase
        send_coef(forced ? dc : dc_value());
        for (int pos = 1; pos < len; pos++) begin
            send_coef((pos <= last_nz && $urandom_range(99) < density) ? ac_value() : 11'd0);
        end
        if (len < BLOCK_COEFFS) begin
            send_flush();
        end else begin
            n_blocks++;
        end
    endtask

    task automatic reload_entries();
        int n;
        n = $urandom_range(4, 1);
        repeat (n) begin
            if ($urandom_range(1)) begin
                send_item(OP_LOAD_AC, 11'($urandom), 8'($urandom), 16'($urandom), entry_len());
            end else begin
                send_item(OP_LOAD_DC, 11'($urandom),
                          ($urandom_range(99) < 80) ? 8'($urandom_range(DC_DEPTH - 1))
                                                    : 8'($urandom),
                          16'($urandom), entry_len());
            end
        end
    endtask

    // Receiver: ready at random, steady during the quiet stretch, and low
    // for the LONG_STALL hold-off whenever the stimulus asks for one.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_served < stall_asked) begin
                stall_served++;
                out_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    // Ends the run if neither channel moves a beat for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat on either channel for %0d cycles", $time, IDLE_LIMIT);
        $display("jpeg_huffman_block_encoder_unit verification failed");
        $finish;
    end

    initial begin
        int  start;
        int  done;
        int  pick;
        int  forced_left;
        bit  drain_done;

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = OP_COEF;
        in_ch.coefficient  = '0;
        in_ch.entry_index  = '0;
        in_ch.entry_code   = '0;
        in_ch.entry_length = '0;
        forced_left        = 2;
        drain_done         = 1'b0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The code tables are undefined until written, so every entry is
        // loaded with a legal random code before any coefficient is sent.
        for (int k = 0; k < DC_DEPTH; k++) begin
            send_item(OP_LOAD_DC, 11'($urandom), 8'(k), 16'($urandom),
                      5'($urandom_range(16, 1)));
        end
        for (int k = 0; k < AC_TABLE_DEPTH; k++) begin
            send_item(OP_LOAD_AC, 11'($urandom), 8'(k), 16'($urandom),
                      5'($urandom_range(16, 1)));
        end

        // Directed: range extremes, saturation, flushes with and without
        // pending bits, ignored DC loads, invalid entries and an all-ones
        // code that forces 0xFF bytes and their stuffed zeros.
        send_coef(11'd1023);
        send_coef(COEF_NEG_MIN);
        send_coef(11'd1);
        send_coef(11'd0);
        send_flush();
        send_flush();
        send_item(OP_LOAD_DC, 11'd0, 8'(DC_DEPTH), 16'hFFFF, 5'd5);
        send_item(OP_LOAD_DC, 11'h7FF, 8'hFF, 16'h0000, 5'd31);
        send_item(OP_LOAD_AC, 11'd0, 8'hFF, 16'hA5A5, 5'd0);
        send_item(OP_LOAD_DC, 11'd0, 8'd1, 16'hFFFF, 5'd0);
        send_coef(11'd1);
        send_coef(11'h7FF);
        send_flush();
        send_item(OP_LOAD_DC, 11'd0, 8'd1, 16'hFFFF, 5'd31);
        send_coef(11'h7FF);
        send_coef(11'(-1023));
        send_flush();

        // Random part: mostly whole blocks, with flushes, table reloads and
        // bursts of arbitrary beats in between. The first two blocks carry
        // opposite extreme DC values, which gives the largest difference.
        start = n_sent;
        while (n_sent - start < RANDOM_ITEMS) begin
            done   = n_sent - start;
            steady = (done >= 60 && done < 130);
            if (!drain_done && done >= 40) begin
                wait_drained();
                drain_done = 1'b1;
            end
            if (stall_asked == 0 && done >= 150) begin
                stall_asked++;
            end
            pick = $urandom_range(99);
            if (forced_left > 0) begin
                coef_block(1'b1, (forced_left == 2) ? 11'd1023 : 11'(-1023));
                forced_left--;
            end else if (pick < 70) begin
                coef_block(1'b0, 11'd0);
            end else if (pick < 80) begin
                send_flush();
            end else if (pick < 90) begin
                if ($urandom_range(1)) begin
                    wait_drained();
                end
                reload_entries();
            end else begin
                // Arbitrary beats, then a flush to line the blocks up again.
                repeat ($urandom_range(5, 1)) begin
                    send_item(t_opcode'($urandom_range(3)), 11'($urandom), 8'($urandom),
                              16'($urandom), 5'($urandom));
                end
                send_flush();
            end
        end
        steady = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d beats in: %0d coefficients (%0d whole blocks), %0d loads, %0d flushes.",
                 n_sent, n_coefs, n_blocks, n_loads, n_flushes);
        $display("Checked %0d result beats, %0d mismatches, %0d still awaited.",
                 beat_count, fail_count, outstanding);
        if (fail_count == 0 && outstanding == 0) begin
            $display("jpeg_huffman_block_encoder_unit verification clean");
        end else begin
            $display("jpeg_huffman_block_encoder_unit verification failed");
        end
        $finish;
    end

endmodule
